// ===== sv/tsi_pkg.sv =====
// Shared types and constants for the toon shade intensity block.
// No dependencies.
package tsi_pkg;

    localparam int FRAC_BITS = 12;
    localparam int COEF_W    = 16;
    localparam int QUO_W     = 2 * FRAC_BITS + 1;  // floor(m^2 * 2^24 / S) <= 2^24
    localparam int UNIT_W    = FRAC_BITS + 1;      // unit magnitude <= 4096
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W     = 3 * COEF_W;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT = 8'd3;

    localparam logic [CFG_W-1:0] RST_ROW_X = 48'h0000_0000_1000;
    localparam logic [CFG_W-1:0] RST_ROW_Y = 48'h0000_1000_0000;
    localparam logic [CFG_W-1:0] RST_ROW_Z = 48'h1000_0000_0000;
    localparam logic [CFG_W-1:0] RST_LIGHT = 48'h1000_1000_F000;

    typedef logic signed [UNIT_W:0] t_unit;

    typedef struct packed {
        logic valid;
        logic zero;
    } t_norm_stat;

endpackage

// ===== sv/tsi_normalize.sv =====
// Pipelined 3-vector normalizer: squares, restoring divide (one bit a stage),
// then digit-by-digit square root (one bit a stage). Depends on tsi_pkg.
module tsi_normalize #(
    parameter int W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [W-1:0]  i_vec [3],
    output tsi_pkg::t_norm_stat  o_stat,
    output tsi_pkg::t_unit       o_unit [3]
);
    localparam int SW   = 2 * W;
    localparam int RW   = SW + 1;
    localparam int QW   = tsi_pkg::QUO_W;
    localparam int NSQ  = tsi_pkg::UNIT_W;
    localparam int RESW = QW + 1;

    logic         r0_valid;
    logic [W-1:0] r0_mag [3];
    logic         r0_neg [3];
    logic          r1_valid;
    logic [SW-1:0] r1_sq [3];
    logic          r1_neg [3];

    logic          r_dv_valid [0:QW];
    logic          r_dv_zero  [0:QW];
    logic [SW-1:0] r_dv_s     [0:QW];
    logic          r_dv_neg   [0:QW][3];
    logic [RW-1:0] r_dv_rem   [0:QW][3];
    logic [QW-1:0] r_dv_q     [0:QW][3];

    logic            r_sq_valid [1:NSQ];
    logic            r_sq_zero  [1:NSQ];
    logic            r_sq_neg   [1:NSQ][3];
    logic [QW-1:0]   r_sq_x     [1:NSQ][3];
    logic [RESW-1:0] r_sq_res   [1:NSQ][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid      <= 1'b0;
            r1_valid      <= 1'b0;
            r_dv_valid[0] <= 1'b0;
        end else begin
            r0_valid      <= i_valid;
            r1_valid      <= r0_valid;
            r_dv_valid[0] <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r0_neg[i] <= i_vec[i][W-1];
            r0_mag[i] <= i_vec[i][W-1] ? W'(-i_vec[i]) : W'(i_vec[i]);
            r1_sq[i]  <= SW'(r0_mag[i]) * SW'(r0_mag[i]);
            r1_neg[i] <= r0_neg[i];
            r_dv_neg[0][i] <= r1_neg[i];
            r_dv_rem[0][i] <= RW'(r1_sq[i]);
            r_dv_q[0][i]   <= '0;
        end
        r_dv_s[0]    <= r1_sq[0] + r1_sq[1] + r1_sq[2];
        r_dv_zero[0] <= (r1_sq[0] | r1_sq[1] | r1_sq[2]) == '0;
    end

    // First divide step has no shift; the remainder stays below S after it.
    for (genvar d = 0; d < QW; d++) begin : g_div
        logic [RW-1:0] sh  [3];
        logic          ge  [3];
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                sh[i] = (d == 0) ? r_dv_rem[d][i] : {r_dv_rem[d][i][RW-2:0], 1'b0};
                ge[i] = sh[i] >= RW'(r_dv_s[d]);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[d+1] <= 1'b0;
            end else begin
                r_dv_valid[d+1] <= r_dv_valid[d];
            end
        end
        always_ff @(posedge i_clk) begin
            r_dv_zero[d+1] <= r_dv_zero[d];
            r_dv_s[d+1]    <= r_dv_s[d];
            for (int i = 0; i < 3; i++) begin
                r_dv_neg[d+1][i] <= r_dv_neg[d][i];
                r_dv_rem[d+1][i] <= ge[i] ? sh[i] - RW'(r_dv_s[d]) : sh[i];
                r_dv_q[d+1][i]   <= {r_dv_q[d][i][QW-2:0], ge[i]};
            end
        end
    end

    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        localparam logic [RESW-1:0] BIT = RESW'(1) << (2 * (NSQ - 1 - k));
        logic            c_valid;
        logic            c_zero;
        logic            c_neg [3];
        logic [QW-1:0]   c_x   [3];
        logic [RESW-1:0] c_res [3];
        logic [RESW-1:0] t     [3];
        logic            ge    [3];
        always_comb begin
            if (k == 0) begin
                c_valid = r_dv_valid[QW];
                c_zero  = r_dv_zero[QW];
            end else begin
                c_valid = r_sq_valid[k];
                c_zero  = r_sq_zero[k];
            end
            for (int i = 0; i < 3; i++) begin
                if (k == 0) begin
                    c_neg[i] = r_dv_neg[QW][i];
                    c_x[i]   = r_dv_q[QW][i];
                    c_res[i] = '0;
                end else begin
                    c_neg[i] = r_sq_neg[k][i];
                    c_x[i]   = r_sq_x[k][i];
                    c_res[i] = r_sq_res[k][i];
                end
                t[i]  = c_res[i] + BIT;
                ge[i] = RESW'(c_x[i]) >= t[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[k+1] <= 1'b0;
            end else begin
                r_sq_valid[k+1] <= c_valid;
            end
        end
        always_ff @(posedge i_clk) begin
            r_sq_zero[k+1] <= c_zero;
            for (int i = 0; i < 3; i++) begin
                r_sq_neg[k+1][i] <= c_neg[i];
                r_sq_x[k+1][i]   <= ge[i] ? c_x[i] - t[i][QW-1:0] : c_x[i];
                r_sq_res[k+1][i] <= ge[i] ? (c_res[i] >> 1) + BIT : c_res[i] >> 1;
            end
        end
    end

    always_comb begin
        o_stat.valid = r_sq_valid[NSQ];
        o_stat.zero  = r_sq_zero[NSQ];
        for (int i = 0; i < 3; i++) begin
            o_unit[i] = r_sq_neg[NSQ][i]
                      ? -$signed({1'b0, r_sq_res[NSQ][i][NSQ-1:0]})
                      :  $signed({1'b0, r_sq_res[NSQ][i][NSQ-1:0]});
        end
    end
endmodule

// ===== sv/tsi_rotate_dot.sv =====
// Rotation by the 3x3 matrix, dot with the unit light, rounding and clamp.
// Four register stages. Depends on tsi_pkg.
module tsi_rotate_dot #(
    parameter int DW = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tsi_pkg::t_norm_stat            i_nstat,
    input  tsi_pkg::t_unit                 i_nunit [3],
    input  tsi_pkg::t_norm_stat            i_lstat,
    input  tsi_pkg::t_unit                 i_lunit [3],
    input  logic [tsi_pkg::CFG_W-1:0]      i_rows  [3],
    output logic                           o_valid,
    output logic signed [DW-1:0]           o_intensity,
    output logic                           o_degenerate
);
    localparam int CW = tsi_pkg::COEF_W;
    localparam int UW = tsi_pkg::UNIT_W + 1;
    localparam int PW = CW + UW;
    localparam int RTW = PW + 2;
    localparam int DPW = RTW + UW;
    localparam int SUMW = DPW + 2;
    localparam int SH = 2 * tsi_pkg::FRAC_BITS;
    localparam logic signed [SUMW-1:0] HALF = SUMW'(1) <<< (SH - 1);
    localparam logic signed [SUMW-1:0] MAXV = (SUMW'(1) <<< (DW - 1)) - SUMW'(1);
    localparam logic signed [SUMW-1:0] MINV = -MAXV - SUMW'(1);

    logic                 ra_valid, rb_valid, rc_valid;
    logic                 ra_deg, rb_deg, rc_deg;
    logic signed [PW-1:0] ra_p [3][3];
    logic signed [UW-1:0] ra_l [3];
    logic signed [RTW-1:0] rb_rot [3];
    logic signed [UW-1:0]  rb_l [3];
    logic signed [DPW-1:0] rc_d [3];

    logic signed [SUMW-1:0] c_sum;
    logic signed [SUMW-1:0] c_res;
    logic signed [SUMW-1:0] c_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_valid <= 1'b0;
            rb_valid <= 1'b0;
            rc_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            ra_valid <= i_nstat.valid;
            rb_valid <= ra_valid;
            rc_valid <= rb_valid;
            o_valid  <= rc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        ra_deg <= i_nstat.zero | i_lstat.zero;
        rb_deg <= ra_deg;
        rc_deg <= rb_deg;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ra_p[i][j] <= PW'($signed(i_rows[i][CW*j +: CW])) * PW'(i_nunit[j]);
            end
            ra_l[i]   <= i_lunit[i];
            rb_rot[i] <= RTW'(ra_p[i][0]) + RTW'(ra_p[i][1]) + RTW'(ra_p[i][2]);
            rb_l[i]   <= ra_l[i];
            rc_d[i]   <= DPW'(rb_l[i]) * DPW'(rb_rot[i]);
        end
    end

    always_comb begin
        c_sum = SUMW'(rc_d[0]) + SUMW'(rc_d[1]) + SUMW'(rc_d[2]) + HALF;
        c_res = c_sum >>> SH;
        if (c_res > MAXV) begin
            c_sat = MAXV;
        end else if (c_res < MINV) begin
            c_sat = MINV;
        end else begin
            c_sat = c_res;
        end
    end

    always_ff @(posedge i_clk) begin
        o_degenerate <= rc_deg;
        o_intensity  <= rc_deg ? '0 : c_sat[DW-1:0];
    end
endmodule

// ===== sv/toon_shade_intensity_top.sv =====
// Top level of the toon shade intensity block: config registers, normal and
// light normalizers, rotate/dot stage. Depends on tsi_pkg and both submodules.
//
//  channel   dir  handshake                 payload
//  command   in   start & !busy             i_normal_x/y/z
//  config    in   i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//  result    out  o_result_valid (1 cycle)  o_intensity, o_degenerate
//
// One word accepted per cycle; busy is always low. Each word passes the input
// registers, the 25-step restoring divider, the 13-step square root and rotate/dot.
// Reset is synchronous and drops any words in flight; registers return to
// identity rotation and light (-1,1,1). Results cannot be stalled.
module toon_shade_intensity_top #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [DATA_WIDTH-1:0]      i_normal_x,
    input  logic signed [DATA_WIDTH-1:0]      i_normal_y,
    input  logic signed [DATA_WIDTH-1:0]      i_normal_z,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tsi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tsi_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                              o_result_valid,
    output logic signed [DATA_WIDTH-1:0]      o_intensity,
    output logic                              o_degenerate
);
    localparam int CW = tsi_pkg::COEF_W;

    logic [tsi_pkg::CFG_W-1:0] r_rows [3];
    logic [tsi_pkg::CFG_W-1:0] r_light;

    logic                  accept;
    logic signed [DATA_WIDTH-1:0] nvec [3];
    logic signed [CW-1:0]  lvec [3];
    tsi_pkg::t_norm_stat   nstat, lstat;
    tsi_pkg::t_unit        nunit [3];
    tsi_pkg::t_unit        lunit [3];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows[0] <= tsi_pkg::RST_ROW_X;
            r_rows[1] <= tsi_pkg::RST_ROW_Y;
            r_rows[2] <= tsi_pkg::RST_ROW_Z;
            r_light   <= tsi_pkg::RST_LIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tsi_pkg::REG_ROW_X: r_rows[0] <= i_cfg_data;
                tsi_pkg::REG_ROW_Y: r_rows[1] <= i_cfg_data;
                tsi_pkg::REG_ROW_Z: r_rows[2] <= i_cfg_data;
                tsi_pkg::REG_LIGHT: r_light   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        nvec[0] = i_normal_x;
        nvec[1] = i_normal_y;
        nvec[2] = i_normal_z;
        for (int i = 0; i < 3; i++) begin
            lvec[i] = $signed(r_light[CW*i +: CW]);
        end
    end

    tsi_normalize #(.W(DATA_WIDTH)) u_norm_n (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_vec   (nvec),
        .o_stat  (nstat),
        .o_unit  (nunit)
    );

    // light is renormalized alongside each word so both arrive together
    tsi_normalize #(.W(CW)) u_norm_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_vec   (lvec),
        .o_stat  (lstat),
        .o_unit  (lunit)
    );

    tsi_rotate_dot #(.DW(DATA_WIDTH)) u_dot (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_nstat      (nstat),
        .i_nunit      (nunit),
        .i_lstat      (lstat),
        .i_lunit      (lunit),
        .i_rows       (r_rows),
        .o_valid      (o_result_valid),
        .o_intensity  (o_intensity),
        .o_degenerate (o_degenerate)
    );
endmodule
